// ===== hdl/sum_tree_weighted_sampler_core_defines.svh =====
// assertion macros for the sum tree sampler
`ifndef SUM_TREE_WEIGHTED_SAMPLER_CORE_DEFINES_SVH
`define SUM_TREE_WEIGHTED_SAMPLER_CORE_DEFINES_SVH

// same-cycle implication
`define SWT_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SWT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/swt_pkg.sv =====
// shared types and constants of the sum tree sampler
package swt_pkg;
   localparam int CAPACITY   = 1024;
   localparam int IDX_W      = 10;
   localparam int COUNT_W    = IDX_W + 1;
   localparam int NODE_W     = IDX_W + 1;
   localparam int NODE_DEPTH = 2 ** NODE_W;
   localparam int WEIGHT_W   = 16;
   localparam int FRAC_W     = 16;
   localparam int PAYLOAD_W  = 32;
   localparam int SUM_W      = WEIGHT_W + IDX_W;
   localparam int PROD_W     = SUM_W + FRAC_W;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 56;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INDEX = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

   localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd2;

   typedef enum logic [1:0] {OP_ADD, OP_UPDATE, OP_SAMPLE, OP_IGNORE} op_type;

   typedef struct packed {
      op_type                op;
      logic [IDX_W-1:0]      slot;
      logic [WEIGHT_W-1:0]   weight;
      logic [FRAC_W-1:0]     frac;
      logic [PAYLOAD_W-1:0]  data;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_ctrl_type;
endpackage

// ===== hdl/swt_ram.sv =====
// generic single write, single read ram with registered read
module swt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== hdl/swt_front.sv =====
// request intake: decodes the kind and queues transactions for the tree engine
module swt_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [swt_pkg::KIND_W-1:0]    req_kind,
   input  swt_pkg::item_type             req_item,
   input  swt_pkg::back_ctrl_type        back_ctrl,
   output swt_pkg::head_type             head
);
   import swt_pkg::*;

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       accept;
   item_type   decoded;

   always_comb begin
      decoded = req_item;
      unique case (req_kind)
         KIND_ADD:    decoded.op = OP_ADD;
         KIND_UPDATE: decoded.op = OP_UPDATE;
         KIND_SAMPLE: decoded.op = OP_SAMPLE;
         default:     decoded.op = OP_IGNORE;
      endcase
   end

   assign req_tready = (fill_ff != 2'd2) && !back_ctrl.clearing;
   assign accept     = req_tvalid && req_tready;

   assign wr_ptr_in = accept ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = back_ctrl.pop ? !rd_ptr_ff : rd_ptr_ff;
   assign fill_in   = fill_ff + {1'b0, accept} - {1'b0, back_ctrl.pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (accept) begin
         q_ff[wr_ptr_ff] <= decoded;
      end
   end

   assign head.valid = (fill_ff != 2'd0);
   assign head.item  = q_ff[rd_ptr_ff];
endmodule

// ===== hdl/swt_back.sv =====
// tree engine: clearing pass, leaf write with sum propagation, weighted descent
`include "sum_tree_weighted_sampler_core_defines.svh"
module swt_back (
   input  logic                           clock,
   input  logic                           reset,
   input  swt_pkg::head_type              head,
   output swt_pkg::back_ctrl_type         back_ctrl,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [swt_pkg::STATUS_W-1:0]   rsp_status,
   output logic [swt_pkg::IDX_W-1:0]      rsp_index,
   output logic [swt_pkg::PAYLOAD_W-1:0]  rsp_data,
   output logic [swt_pkg::COUNT_W-1:0]    rsp_count
);
   import swt_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_UP_RD, S_UP_WR, S_MUL, S_DN_RD, S_DN_CMP, S_FIN
   } state_type;

   state_type            state_ff;
   logic [NODE_W-1:0]    clr_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [NODE_W-1:0]    node_ff;
   logic [SUM_W-1:0]     cur_ff;
   logic [SUM_W-1:0]     rem_ff;
   logic [FRAC_W-1:0]    frac_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [PAYLOAD_W-1:0] data_ff;
   logic                 use_pay_ff;
   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [IDX_W-1:0]     rsp_index_ff;
   logic [PAYLOAD_W-1:0] rsp_data_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   logic                 tree_we, tree_re;
   logic [NODE_W-1:0]    tree_waddr, tree_raddr;
   logic [SUM_W-1:0]     tree_wdata, tree_rdata;
   logic                 pay_we, pay_re;
   logic [IDX_W-1:0]     pay_waddr, pay_raddr;
   logic [PAYLOAD_W-1:0] pay_rdata;

   logic                 out_free, pop;
   logic                 not_full, slot_ok, pick_ok;
   logic                 quick_rsp, rsp_load;
   logic [SUM_W-1:0]     up_sum;
   logic [PROD_W-1:0]    product;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop      = (state_ff == S_IDLE) && head.valid && out_free;
   assign not_full = count_ff < COUNT_W'(CAPACITY);
   assign slot_ok  = {1'b0, head.item.slot} < count_ff;
   assign pick_ok  = {1'b0, node_ff[IDX_W-1:0]} < count_ff;
   assign up_sum   = cur_ff + tree_rdata;
   assign product  = PROD_W'(frac_ff) * PROD_W'(tree_rdata);

   // transactions answered straight from the idle state
   assign quick_rsp = (head.item.op == OP_ADD)    ? !not_full :
                      (head.item.op == OP_UPDATE) ? !slot_ok :
                      (head.item.op == OP_SAMPLE) ? (count_ff == '0) : 1'b1;
   assign rsp_load  = (pop && quick_rsp)
                   || ((state_ff == S_UP_RD) && (node_ff == NODE_W'(1)))
                   || ((state_ff == S_DN_RD) && node_ff[NODE_W-1] && !pick_ok)
                   || (state_ff == S_FIN);

   assign back_ctrl.pop      = pop;
   assign back_ctrl.clearing = (state_ff == S_CLEAR);

   always_comb begin
      tree_we    = 1'b0;
      tree_waddr = node_ff;
      tree_wdata = '0;
      tree_re    = 1'b0;
      tree_raddr = node_ff;
      pay_we     = 1'b0;
      pay_waddr  = count_ff[IDX_W-1:0];
      pay_re     = 1'b0;
      pay_raddr  = node_ff[IDX_W-1:0];
      unique case (state_ff)
         S_CLEAR: begin
            tree_we    = 1'b1;
            tree_waddr = clr_ff;
         end
         S_IDLE: begin
            if (pop) begin
               unique case (head.item.op)
                  OP_ADD: begin
                     if (not_full) begin
                        pay_we     = 1'b1;
                        tree_we    = 1'b1;
                        tree_waddr = {1'b1, count_ff[IDX_W-1:0]};
                        tree_wdata = SUM_W'(head.item.weight);
                     end
                  end
                  OP_UPDATE: begin
                     if (slot_ok) begin
                        pay_re     = 1'b1;
                        pay_raddr  = head.item.slot;
                        tree_we    = 1'b1;
                        tree_waddr = {1'b1, head.item.slot};
                        tree_wdata = SUM_W'(head.item.weight);
                     end
                  end
                  OP_SAMPLE: begin
                     if (count_ff != '0) begin
                        tree_re    = 1'b1;
                        tree_raddr = NODE_W'(1);
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_UP_RD: begin
            tree_re    = (node_ff != NODE_W'(1));
            tree_raddr = node_ff ^ NODE_W'(1);
         end
         S_UP_WR: begin
            tree_we    = 1'b1;
            tree_waddr = node_ff >> 1;
            tree_wdata = up_sum;
         end
         S_DN_RD: begin
            if (node_ff[NODE_W-1]) begin
               pay_re = pick_ok;
            end else begin
               tree_re    = 1'b1;
               tree_raddr = {node_ff[NODE_W-2:0], 1'b0};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == NODE_W'(NODE_DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (pop) begin
                  frac_ff <= head.item.frac;
                  data_ff <= head.item.data;
                  cur_ff  <= SUM_W'(head.item.weight);
                  unique case (head.item.op)
                     OP_ADD: begin
                        if (not_full) begin
                           idx_ff     <= count_ff[IDX_W-1:0];
                           node_ff    <= {1'b1, count_ff[IDX_W-1:0]};
                           use_pay_ff <= 1'b0;
                           count_ff   <= count_ff + 1'b1;
                           state_ff   <= S_UP_RD;
                        end else begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_status_ff <= ST_FULL;
                           rsp_index_ff  <= '0;
                           rsp_data_ff   <= '0;
                           rsp_count_ff  <= count_ff;
                        end
                     end
                     OP_UPDATE: begin
                        if (slot_ok) begin
                           idx_ff     <= head.item.slot;
                           node_ff    <= {1'b1, head.item.slot};
                           use_pay_ff <= 1'b1;
                           state_ff   <= S_UP_RD;
                        end else begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_status_ff <= ST_INDEX;
                           rsp_index_ff  <= '0;
                           rsp_data_ff   <= '0;
                           rsp_count_ff  <= count_ff;
                        end
                     end
                     OP_SAMPLE: begin
                        if (count_ff != '0) begin
                           state_ff <= S_MUL;
                        end else begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_status_ff <= ST_EMPTY;
                           rsp_index_ff  <= '0;
                           rsp_data_ff   <= '0;
                           rsp_count_ff  <= count_ff;
                        end
                     end
                     default: begin
                        rsp_valid_ff  <= 1'b1;
                        rsp_status_ff <= ST_OK;
                        rsp_index_ff  <= '0;
                        rsp_data_ff   <= '0;
                        rsp_count_ff  <= count_ff;
                     end
                  endcase
               end
            end
            S_UP_RD: begin
               if (node_ff == NODE_W'(1)) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= ST_OK;
                  rsp_index_ff  <= idx_ff;
                  rsp_data_ff   <= use_pay_ff ? pay_rdata : data_ff;
                  rsp_count_ff  <= count_ff;
                  state_ff      <= S_IDLE;
               end else begin
                  state_ff <= S_UP_WR;
               end
            end
            S_UP_WR: begin
               cur_ff   <= up_sum;
               node_ff  <= node_ff >> 1;
               state_ff <= S_UP_RD;
            end
            S_MUL: begin
               // rem = (fraction * total) >> fraction bits
               rem_ff   <= product[PROD_W-1:FRAC_W];
               node_ff  <= NODE_W'(1);
               state_ff <= S_DN_RD;
            end
            S_DN_RD: begin
               if (node_ff[NODE_W-1]) begin
                  if (pick_ok) begin
                     idx_ff   <= node_ff[IDX_W-1:0];
                     state_ff <= S_FIN;
                  end else begin
                     // all-zero weights walk off the stored range unless all slots are filled
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= ST_INDEX;
                     rsp_index_ff  <= '0;
                     rsp_data_ff   <= '0;
                     rsp_count_ff  <= count_ff;
                     state_ff      <= S_IDLE;
                  end
               end else begin
                  state_ff <= S_DN_CMP;
               end
            end
            S_DN_CMP: begin
               if (tree_rdata <= rem_ff) begin
                  rem_ff  <= rem_ff - tree_rdata;
                  node_ff <= {node_ff[NODE_W-2:0], 1'b1};
               end else begin
                  node_ff <= {node_ff[NODE_W-2:0], 1'b0};
               end
               state_ff <= S_DN_RD;
            end
            S_FIN: begin
               rsp_valid_ff  <= 1'b1;
               rsp_status_ff <= ST_OK;
               rsp_index_ff  <= idx_ff;
               rsp_data_ff   <= pay_rdata;
               rsp_count_ff  <= count_ff;
               state_ff      <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   swt_ram #(.WIDTH(SUM_W), .DEPTH(NODE_DEPTH)) u_tree_ram (
      .clock (clock),
      .we    (tree_we),
      .waddr (tree_waddr),
      .wdata (tree_wdata),
      .re    (tree_re),
      .raddr (tree_raddr),
      .rdata (tree_rdata)
   );

   swt_ram #(.WIDTH(PAYLOAD_W), .DEPTH(CAPACITY)) u_payload_ram (
      .clock (clock),
      .we    (pay_we),
      .waddr (pay_waddr),
      .wdata (head.item.data),
      .re    (pay_re),
      .raddr (pay_raddr),
      .rdata (pay_rdata)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_count  = rsp_count_ff;

   `SWT_ASSERT(count_in_range, clock, reset, 1'b1, count_ff <= COUNT_W'(CAPACITY), "count past capacity")
   `SWT_ASSERT_NEXT(add_counts_up, clock, reset, pop && head.item.op == OP_ADD && not_full, count_ff == COUNT_W'($past(count_ff) + 1'b1), "add did not bump count")
   `SWT_ASSERT(quiet_while_clearing, clock, reset, state_ff == S_CLEAR, !rsp_valid_ff && !pop, "activity during clearing pass")
   `SWT_ASSERT(descent_is_read_only, clock, reset, state_ff == S_DN_RD || state_ff == S_DN_CMP, !tree_we && !pay_we, "tree written during descent")
endmodule

// ===== hdl/sum_tree_weighted_sampler_core.sv =====
// add or update: leaf write, then read sibling / write parent per level
// sample: root read, multiply, read and compare per level, payload read
// one request in the tree engine at a time; a two-entry queue and the result register
// decouple the sides
// synchronous active-high reset; afterwards a clearing pass zeroes all 2048 tree nodes,
// during which req_tready stays low
// payload store is not cleared and is valid only where written
module sum_tree_weighted_sampler_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // slot_index[9:0], weight_value[25:10], random_fraction[41:26], element_data[73:42], zero pad
   input  logic [swt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind[1:0]
   input  logic [swt_pkg::KIND_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // chosen_index[9:0], chosen_data[41:10], element_count[52:42], zero pad
   output logic [swt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status[1:0]
   output logic [swt_pkg::STATUS_W-1:0]     rsp_tuser
);
   import swt_pkg::*;

   item_type             req_item;
   head_type             head;
   back_ctrl_type        back_ctrl;
   logic [IDX_W-1:0]     rsp_index;
   logic [PAYLOAD_W-1:0] rsp_data;
   logic [COUNT_W-1:0]   rsp_count;

   assign req_item.op     = OP_IGNORE;
   assign req_item.slot   = req_tdata[9:0];
   assign req_item.weight = req_tdata[25:10];
   assign req_item.frac   = req_tdata[41:26];
   assign req_item.data   = req_tdata[73:42];

   swt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .req_item   (req_item),
      .back_ctrl  (back_ctrl),
      .head       (head)
   );

   swt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .back_ctrl  (back_ctrl),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_index  (rsp_index),
      .rsp_data   (rsp_data),
      .rsp_count  (rsp_count)
   );

   assign rsp_tdata = {3'b000, rsp_count, rsp_data, rsp_index};
endmodule
